### rtl/sbd_pkg.sv
// Shared types and constants for the six-button debouncer with mode select.
package sbd_pkg;

	localparam int NUM_BTN   = 6;
	localparam int NUM_CHORD = 3;   // buttons 0..2 form the chord and select the mode
	localparam int BTN_RESET = 3;
	localparam int CNT_W     = 8;   // debounce counter width, 8..16
	localparam int THR_W     = 8;   // threshold register width
	localparam int CFG_IDX_W = 3;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REARM      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CHORD      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RESET_HOLD = 3'd4;

	localparam logic [THR_W-1:0] PRESS_RST      = 8'd4;
	localparam logic [THR_W-1:0] RELEASE_RST    = 8'd4;
	localparam logic [THR_W-1:0] REARM_RST      = 8'd8;
	localparam logic [THR_W-1:0] CHORD_RST      = 8'd50;
	localparam logic [THR_W-1:0] RESET_HOLD_RST = 8'd200;

	typedef enum logic [1:0] {
		PH_NOMINAL  = 2'd0,
		PH_PRESSED  = 2'd1,
		PH_RELEASED = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		MODE_NORMAL   = 2'd0,
		MODE_IDLE     = 2'd1,
		MODE_LIGHT_1H = 2'd2
	} mode_t;

	typedef struct packed {
		logic [THR_W-1:0] press;
		logic [THR_W-1:0] release_thr;
		logic [THR_W-1:0] rearm;
		logic [THR_W-1:0] chord;
		logic [THR_W-1:0] reset_hold;
	} thr_cfg_t;

	// per-button status after this tick
	typedef struct packed {
		phase_t           phase;
		logic [CNT_W-1:0] on_cnt;
		logic             held_pressed;
	} lane_stat_t;

	typedef struct packed {
		logic [1:0]         unit_mode;
		logic               update_screen;
		logic               diag_active;
		logic               diag_timer_start;
		logic               clear_faults;
		logic [NUM_BTN-1:0] pressed_mask;
	} tick_res_t;

endpackage

### rtl/sbd_if.sv
// Handshake interfaces for the button sample and tick result channels.
interface sbd_in_if import sbd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [NUM_BTN-1:0] button_levels;

	modport source (output valid, output button_levels, input ready);
	modport sink (input valid, input button_levels, output ready);
endinterface

interface sbd_out_if import sbd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         unit_mode;
	logic               update_screen;
	logic               diag_active;
	logic               diag_timer_start;
	logic               clear_faults;
	logic [NUM_BTN-1:0] pressed_mask;

	modport source (output valid, output unit_mode, output update_screen, output diag_active,
		output diag_timer_start, output clear_faults, output pressed_mask, input ready);
	modport sink (input valid, input unit_mode, input update_screen, input diag_active,
		input diag_timer_start, input clear_faults, input pressed_mask, output ready);
endinterface

### rtl/sbd_lane.sv
// One button: nominal / pressed / released debounce machine with on and off counters.
module sbd_lane import sbd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic       level,
	input  thr_cfg_t   cfg,
	output lane_stat_t stat
);

	phase_t           phase_q, phase_nx;
	logic [CNT_W-1:0] on_q, on_nx, on_inc;
	logic [CNT_W-1:0] off_q, off_nx, off_inc;
	logic [CNT_W:0]   off_n;
	logic             held;
	logic             held_pressed;

	always_comb begin
		held    = ~level;
		on_inc  = (on_q == CNT_MAX) ? on_q : on_q + 1'b1;
		off_inc = (off_q == CNT_MAX) ? off_q : off_q + 1'b1;
		// unsaturated off count, so a threshold at full scale is still reachable
		off_n   = {1'b0, off_q} + 1'b1;
		phase_nx     = phase_q;
		on_nx        = on_q;
		off_nx       = off_q;
		held_pressed = 1'b0;
		unique case (phase_q)
			PH_NOMINAL: begin
				if (held) begin
					on_nx = on_inc;
					if (on_inc == CNT_W'(cfg.press))
						phase_nx = PH_PRESSED;
				end else begin
					on_nx = '0;
				end
			end
			PH_PRESSED: begin
				if (!held) begin
					off_nx = off_inc;
					if (off_n > (CNT_W+1)'(cfg.release_thr))
						phase_nx = PH_RELEASED;
				end else begin
					on_nx        = on_inc;
					held_pressed = 1'b1;
				end
			end
			PH_RELEASED: begin
				if (!held) begin
					off_nx = off_inc;
					if (off_n > (CNT_W+1)'(cfg.rearm)) begin
						on_nx    = '0;
						off_nx   = '0;
						phase_nx = PH_NOMINAL;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NOMINAL;
			on_q    <= '0;
			off_q   <= '0;
		end else if (advance) begin
			phase_q <= phase_nx;
			on_q    <= on_nx;
			off_q   <= off_nx;
		end
	end

	assign stat.phase        = phase_nx;
	assign stat.on_cnt       = on_nx;
	assign stat.held_pressed = held_pressed;

endmodule

### rtl/sbd_merge.sv
// Merges lane status: diagnostic chord, mode selection and long-hold reset action.
module sbd_merge import sbd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     advance,
	input  thr_cfg_t                 cfg,
	input  lane_stat_t [NUM_BTN-1:0] stat,
	output tick_res_t                res
);

	logic  armed_q, armed_now, armed_nx;
	logic  diag_q, diag_nx;
	mode_t mode_q, mode_nx;
	logic  chord, fire, upd, clr;
	logic [NUM_BTN-1:0] mask;

	always_comb begin
		armed_now = armed_q | stat[BTN_RESET].held_pressed;
		chord = 1'b1;
		for (int i = 0; i < NUM_CHORD; i++)
			chord &= (stat[i].phase == PH_PRESSED) && (stat[i].on_cnt >= CNT_W'(cfg.chord));
		diag_nx = diag_q | chord;

		// visit from the top so the lowest released button has the last word
		mode_nx = mode_q;
		upd     = 1'b0;
		if (!diag_nx) begin
			for (int i = NUM_CHORD - 1; i >= 0; i--) begin
				if (stat[i].phase == PH_RELEASED) begin
					if (mode_nx != mode_t'(i))
						mode_nx = mode_t'(i);
					else
						upd = 1'b1;
				end
			end
		end

		fire     = armed_now && (stat[BTN_RESET].on_cnt >= CNT_W'(cfg.reset_hold));
		clr      = 1'b0;
		armed_nx = armed_now;
		if (fire) begin
			if (diag_nx) begin
				diag_nx = 1'b0;
			end else begin
				clr = 1'b1;
				upd = 1'b1;
			end
			armed_nx = 1'b0;
		end

		for (int i = 0; i < NUM_BTN; i++)
			mask[i] = (stat[i].phase == PH_PRESSED);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			diag_q  <= 1'b0;
			mode_q  <= MODE_NORMAL;
		end else if (advance) begin
			armed_q <= armed_nx;
			diag_q  <= diag_nx;
			mode_q  <= mode_nx;
		end
	end

	assign res.unit_mode        = mode_nx;
	assign res.update_screen    = upd;
	assign res.diag_active      = diag_nx;
	assign res.diag_timer_start = chord;
	assign res.clear_faults     = clr;
	assign res.pressed_mask     = mask;

endmodule

### rtl/six_button_debounce_mode_select.sv
// Top level: six debounce lanes, merge logic, threshold registers and result register.
//
//  channel   dir  transaction                 payload
//  buttons   in   one debounce tick           button_levels[5:0], low = held
//  result    out  one status word per tick    unit_mode, update_screen, diag_active,
//                                             diag_timer_start, clear_faults, pressed_mask
//  cfg       in   register write, no wait     cfg_index, cfg_data
//
// One tick per cycle unless the result stalls: the six lanes and the merge logic are
// combinational, and the result is in the output register the cycle after acceptance.
// Reset clears all button machines, counters and flags and loads default thresholds.
// A stalled result register holds; a new tick is taken in the same cycle the
// pending result leaves, and held off only while the result waits.
module six_button_debounce_mode_select import sbd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	sbd_in_if.sink               buttons,
	sbd_out_if.source            result,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [THR_W-1:0]     cfg_data
);

	thr_cfg_t                 cfg_q;
	lane_stat_t [NUM_BTN-1:0] stat;
	tick_res_t                res, res_q;
	logic                     out_valid_q;
	logic                     advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press       <= PRESS_RST;
			cfg_q.release_thr <= RELEASE_RST;
			cfg_q.rearm       <= REARM_RST;
			cfg_q.chord       <= CHORD_RST;
			cfg_q.reset_hold  <= RESET_HOLD_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_PRESS:      cfg_q.press       <= cfg_data;
				CFG_RELEASE:    cfg_q.release_thr <= cfg_data;
				CFG_REARM:      cfg_q.rearm       <= cfg_data;
				CFG_CHORD:      cfg_q.chord       <= cfg_data;
				CFG_RESET_HOLD: cfg_q.reset_hold  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign buttons.ready = !out_valid_q || result.ready;
	assign advance       = buttons.valid && buttons.ready;

	for (genvar g = 0; g < NUM_BTN; g++) begin : g_lane
		sbd_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.advance(advance),
			.level  (buttons.button_levels[g]),
			.cfg    (cfg_q),
			.stat   (stat[g])
		);
	end

	sbd_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.cfg    (cfg_q),
		.stat   (stat),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res;
	end

	assign result.valid            = out_valid_q;
	assign result.unit_mode        = res_q.unit_mode;
	assign result.update_screen    = res_q.update_screen;
	assign result.diag_active      = res_q.diag_active;
	assign result.diag_timer_start = res_q.diag_timer_start;
	assign result.clear_faults     = res_q.clear_faults;
	assign result.pressed_mask     = res_q.pressed_mask;

	// an accepted tick always shows up as a result on the next cycle
	a_tick_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result.valid)
		else $error("accepted tick produced no result");

	// no new tick while a result waits unaccepted
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |-> !buttons.ready)
		else $error("tick accepted while result stalled");

	// the fault clear comes with a screen update
	a_clr_upd: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.clear_faults) |-> result.update_screen)
		else $error("clear_faults without update_screen");

	// fault clear only fires outside diagnostic mode
	a_clr_diag: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.clear_faults) |-> !result.diag_active)
		else $error("clear_faults while diagnostic mode active");

endmodule

### bench/six_button_debounce_mode_select_tb.sv
// Testbench for the six-button debouncer: directed, saturation and random tick sequences.
`timescale 1ns / 1ps

module six_button_debounce_mode_select_tb;
	import sbd_pkg::*;

	localparam int STALL_LIMIT = 2000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [THR_W-1:0]     cfg_data;

	sbd_in_if  btn_ch ();
	sbd_out_if res_ch ();

	six_button_debounce_mode_select DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.buttons   (btn_ch),
		.result    (res_ch),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// predictor state
	phase_t           btn_phase [NUM_BTN] = '{default: PH_NOMINAL};
	logic [CNT_W-1:0] btn_on    [NUM_BTN] = '{default: '0};
	logic [CNT_W-1:0] btn_off   [NUM_BTN] = '{default: '0};
	logic             rst_armed = 1'b0;
	logic             diag_on   = 1'b0;
	mode_t            cur_mode  = MODE_NORMAL;
	thr_cfg_t         thr = '{PRESS_RST, RELEASE_RST, REARM_RST, CHORD_RST, RESET_HOLD_RST};

	tick_res_t pending_status_q[$];
	int        status_errors = 0;
	int        ticks_sent    = 0;
	int        idle_cycles   = 0;
	int        res_stall     = 0;
	bit        gaps_on       = 1'b1;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [CNT_W-1:0] sat_up(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	// one debounce tick of the predictor; returns the status word it should produce
	function automatic tick_res_t debounce_tick(input logic [NUM_BTN-1:0] levels);
		tick_res_t      r;
		logic [CNT_W:0] next_off;
		logic           held;
		logic           chord;
		int             b;
		r = '0;
		for (b = 0; b < NUM_BTN; b++) begin
			held = !levels[b];
			case (btn_phase[b])
				PH_NOMINAL: begin
					if (held) begin
						btn_on[b] = sat_up(btn_on[b]);
						if (btn_on[b] == thr.press)
							btn_phase[b] = PH_PRESSED;
					end else begin
						btn_on[b] = '0;
					end
				end
				PH_PRESSED: begin
					if (!held) begin
						next_off = {1'b0, btn_off[b]} + 1'b1;
						btn_off[b] = sat_up(btn_off[b]);
						if (next_off > thr.release_thr)
							btn_phase[b] = PH_RELEASED;
					end else begin
						btn_on[b] = sat_up(btn_on[b]);
						if (b == BTN_RESET)
							rst_armed = 1'b1;
					end
				end
				PH_RELEASED: begin
					if (!held) begin
						// threshold sees the count before it saturates
						next_off = {1'b0, btn_off[b]} + 1'b1;
						btn_off[b] = sat_up(btn_off[b]);
						if (next_off > thr.rearm) begin
							btn_on[b]    = '0;
							btn_off[b]   = '0;
							btn_phase[b] = PH_NOMINAL;
						end
					end
				end
				default: ;
			endcase
		end

		chord = 1'b1;
		for (b = 0; b < NUM_CHORD; b++)
			if (!(btn_phase[b] == PH_PRESSED && btn_on[b] >= thr.chord))
				chord = 1'b0;
		if (chord) begin
			diag_on = 1'b1;
			r.diag_timer_start = 1'b1;
		end

		// lowest released index is visited last, so it wins
		if (!diag_on) begin
			for (b = NUM_CHORD - 1; b >= 0; b--) begin
				if (btn_phase[b] == PH_RELEASED) begin
					if (cur_mode != b)
						cur_mode = mode_t'(b);
					else
						r.update_screen = 1'b1;
				end
			end
		end

		if (rst_armed && btn_on[BTN_RESET] >= thr.reset_hold) begin
			if (diag_on) begin
				diag_on = 1'b0;
			end else begin
				r.clear_faults  = 1'b1;
				r.update_screen = 1'b1;
			end
			rst_armed = 1'b0;
		end

		for (b = 0; b < NUM_BTN; b++)
			r.pressed_mask[b] = (btn_phase[b] == PH_PRESSED);
		r.unit_mode   = cur_mode;
		r.diag_active = diag_on;
		return r;
	endfunction

	task automatic send_tick(input logic [NUM_BTN-1:0] levels);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			btn_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		btn_ch.valid         <= 1'b1;
		btn_ch.button_levels <= levels;
		@(posedge clk);
		while (!btn_ch.ready)
			@(posedge clk);
		pending_status_q.push_back(debounce_tick(levels));
		ticks_sent++;
	endtask

	task automatic hold_levels(input logic [NUM_BTN-1:0] levels, input int n);
		repeat (n) send_tick(levels);
	endtask

	// stop sending and wait for every outstanding status word
	task automatic wait_drained();
		btn_ch.valid <= 1'b0;
		while (pending_status_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic load_thresholds(input thr_cfg_t t);
		write_reg(CFG_PRESS, t.press);
		write_reg(CFG_RELEASE, t.release_thr);
		write_reg(CFG_REARM, t.rearm);
		write_reg(CFG_CHORD, t.chord);
		write_reg(CFG_RESET_HOLD, t.reset_hold);
		cfg_write <= 1'b0;
		thr = t;
	endtask

	// a plain press and release of the standby button with reset thresholds
	task automatic test_reset_thresholds();
		hold_levels(6'b111111, 1);
		hold_levels(6'b111101, 4);
		hold_levels(6'b111111, 5);
	endtask

	// shortest thresholds: two-button select, reselect, chord, reset hold, all held
	task automatic test_short_thresholds();
		wait_drained();
		load_thresholds('{8'd1, 8'd1, 8'd1, 8'd1, 8'd1});
		hold_levels(6'b111010, 1);
		hold_levels(6'b111111, 2);
		hold_levels(6'b111110, 1);
		hold_levels(6'b111111, 2);
		hold_levels(6'b111000, 2);
		hold_levels(6'b111111, 3);
		hold_levels(6'b110111, 3);
		hold_levels(6'b111111, 3);
		hold_levels(6'b000000, 1);
		hold_levels(6'b111111, 2);
	endtask

	// largest thresholds: on and off counters run into saturation
	task automatic test_saturation();
		wait_drained();
		load_thresholds('{8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
		hold_levels(6'b110000, 258);
		hold_levels(6'b111111, 259);
	endtask

	task automatic test_random_sequences();
		thr_cfg_t         t;
		logic [NUM_BTN-1:0] held_mask;
		int               stop_at;
		int               phase_end;
		int               b;
		stop_at = ticks_sent + 600;
		while (ticks_sent < stop_at) begin
			t.press       = THR_W'($urandom_range(1, 5));
			t.release_thr = THR_W'($urandom_range(1, 5));
			t.rearm       = THR_W'($urandom_range(1, 8));
			t.chord       = THR_W'($urandom_range(1, 10));
			t.reset_hold  = THR_W'($urandom_range(1, 15));
			wait_drained();
			load_thresholds(t);
			gaps_on   = ($urandom_range(0, 3) != 0);
			phase_end = ticks_sent + 100;
			while (ticks_sent < phase_end) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: begin
						held_mask = NUM_BTN'($urandom_range(1, 63));
						hold_levels(~held_mask, $urandom_range(1, t.press + t.chord + 3));
						hold_levels(6'b111111, $urandom_range(1, t.release_thr + t.rearm + 3));
					end
					4, 5: begin
						held_mask = 6'b000111 | NUM_BTN'($urandom_range(0, 7) << 3);
						hold_levels(~held_mask, t.press + t.chord + $urandom_range(0, 4));
						hold_levels(6'b111111, t.release_thr + t.rearm + 2);
					end
					6: begin
						held_mask = 6'b001000 | NUM_BTN'($urandom_range(0, 1) << 4);
						hold_levels(~held_mask, t.press + t.reset_hold + $urandom_range(0, 3));
						hold_levels(6'b111111, $urandom_range(1, t.release_thr + t.rearm + 3));
					end
					7: begin
						b = $urandom_range(0, NUM_CHORD - 1);
						held_mask = 6'b000001 << b;
						hold_levels(~held_mask, t.press + $urandom_range(0, 2));
						hold_levels(6'b111111, $urandom_range(t.release_thr + 1,
							t.release_thr + t.rearm + 3));
					end
					default: begin
						// bouncing contacts
						repeat ($urandom_range(1, 6))
							send_tick(NUM_BTN'($urandom_range(0, 63)));
					end
				endcase
			end
		end
	endtask

	// result side: random stalls after each transaction
	always @(posedge clk) begin
		if (res_stall > 0)
			res_stall--;
		else if (res_ch.valid && res_ch.ready)
			res_stall = pick_gap();
		res_ch.ready <= (res_stall == 0);
	end

	always @(posedge clk) begin : check_status
		tick_res_t want;
		tick_res_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = '{unit_mode: res_ch.unit_mode, update_screen: res_ch.update_screen,
				diag_active: res_ch.diag_active, diag_timer_start: res_ch.diag_timer_start,
				clear_faults: res_ch.clear_faults, pressed_mask: res_ch.pressed_mask};
			if (pending_status_q.size() == 0) begin
				status_errors++;
				if (status_errors <= 10)
					$display("unexpected status word: mode=%0d upd=%b diag=%b tstart=%b clr=%b mask=%b",
						got.unit_mode, got.update_screen, got.diag_active,
						got.diag_timer_start, got.clear_faults, got.pressed_mask);
			end else begin
				want = pending_status_q.pop_front();
				if (got !== want) begin
					status_errors++;
					if (status_errors <= 10) begin
						$display("status mismatch at %0t:", $realtime);
						$display("  exp mode=%0d upd=%b diag=%b tstart=%b clr=%b mask=%b",
							want.unit_mode, want.update_screen, want.diag_active,
							want.diag_timer_start, want.clear_faults, want.pressed_mask);
						$display("  got mode=%0d upd=%b diag=%b tstart=%b clr=%b mask=%b",
							got.unit_mode, got.update_screen, got.diag_active,
							got.diag_timer_start, got.clear_faults, got.pressed_mask);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((btn_ch.valid && btn_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		arst_n               = 1'b0;
		btn_ch.valid         = 1'b0;
		btn_ch.button_levels = '1;
		res_ch.ready         = 1'b0;
		cfg_write            = 1'b0;
		cfg_index            = CFG_PRESS;
		cfg_data             = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_thresholds();
		test_short_thresholds();
		test_saturation();
		test_random_sequences();

		wait_drained();
		repeat (4) @(posedge clk);
		if (status_errors == 0 && pending_status_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
